@@ sv/pst_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pst_pkg: shared types and constants for the Pascal subset tokenizer
// Token kind codes, lexer modes, character codes, keyword tables and the
// result transaction format shared by the lexer and the result queue.
// ----------------------------------------------------------------------------
package pst_pkg;

    // Token kind codes
    localparam logic [4:0] KIND_END       = 5'd0;
    localparam logic [4:0] KIND_IDENT     = 5'd1;
    localparam logic [4:0] KIND_INTEGER   = 5'd2;
    localparam logic [4:0] KIND_FLOAT     = 5'd3;
    localparam logic [4:0] KIND_STAR      = 5'd4;
    localparam logic [4:0] KIND_SLASH     = 5'd5;
    localparam logic [4:0] KIND_PLUS      = 5'd6;
    localparam logic [4:0] KIND_MINUS     = 5'd7;
    localparam logic [4:0] KIND_LPAREN    = 5'd8;
    localparam logic [4:0] KIND_RPAREN    = 5'd9;
    localparam logic [4:0] KIND_RBRACE    = 5'd10;
    localparam logic [4:0] KIND_ASSIGN    = 5'd11;
    localparam logic [4:0] KIND_SEMI      = 5'd12;
    localparam logic [4:0] KIND_COLON     = 5'd13;
    localparam logic [4:0] KIND_COMMA     = 5'd14;
    localparam logic [4:0] KIND_DOT       = 5'd15;
    localparam logic [4:0] KIND_FIRST_KW  = 5'd16;
    localparam logic [4:0] KIND_ERROR     = 5'd24;

    // Character codes
    localparam logic [7:0] CH_STAR       = 8'h2A;
    localparam logic [7:0] CH_SLASH      = 8'h2F;
    localparam logic [7:0] CH_PLUS       = 8'h2B;
    localparam logic [7:0] CH_MINUS      = 8'h2D;
    localparam logic [7:0] CH_LPAREN     = 8'h28;
    localparam logic [7:0] CH_RPAREN     = 8'h29;
    localparam logic [7:0] CH_LBRACE     = 8'h7B;
    localparam logic [7:0] CH_RBRACE     = 8'h7D;
    localparam logic [7:0] CH_SEMI       = 8'h3B;
    localparam logic [7:0] CH_COLON      = 8'h3A;
    localparam logic [7:0] CH_COMMA      = 8'h2C;
    localparam logic [7:0] CH_DOT        = 8'h2E;
    localparam logic [7:0] CH_EQUAL      = 8'h3D;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_CR         = 8'h0D;
    localparam logic [7:0] CH_ZERO       = 8'h30;
    localparam logic [7:0] CH_NINE       = 8'h39;
    localparam logic [7:0] CH_UPPER_A    = 8'h41;
    localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
    localparam logic [7:0] CH_LOWER_A    = 8'h61;
    localparam logic [7:0] CH_LOWER_Z    = 8'h7A;

    // Keyword table, in kind code order BEGIN..DIV
    localparam int KW_COUNT   = 8;
    localparam int KW_MAX_LEN = 9;

    localparam logic [7:0] KW_CHARS [KW_COUNT][KW_MAX_LEN] = '{
        '{"B", "E", "G", "I", "N", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"E", "N", "D", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"P", "R", "O", "G", "R", "A", "M", 8'h00, 8'h00},
        '{"P", "R", "O", "C", "E", "D", "U", "R", "E"},
        '{"V", "A", "R", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"I", "N", "T", "E", "G", "E", "R", 8'h00, 8'h00},
        '{"R", "E", "A", "L", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"D", "I", "V", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };

    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd5, 4'd3, 4'd7, 4'd9, 4'd3, 4'd7, 4'd4, 4'd3
    };

    // Result queue sizing
    localparam int MAX_RESULTS = 3;
    localparam int QUEUE_DEPTH = 4;

    // Lexer modes
    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_IDENT   = 3'd1,
        MODE_INT     = 3'd2,
        MODE_FRAC    = 3'd3,
        MODE_COLON   = 3'd4,
        MODE_COMMENT = 3'd5,
        MODE_ERROR   = 3'd6
    } lex_mode_t;

    // One result transaction
    typedef struct packed {
        logic [4:0]  kind;
        logic [31:0] num_value;
        logic [3:0]  frac_digits;
        logic        overflowed;
        logic [63:0] name_chars;
        logic [7:0]  name_length;
        logic        last_result;
    } result_t;

    // Results produced by one accepted byte
    typedef struct packed {
        logic [1:0]    count;
        result_t [2:0] item;
    } push_t;

    function automatic result_t mk_token(input logic [4:0] kind);
        result_t r;
        r      = '0;
        r.kind = kind;
        return r;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) ||
               ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z));
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_ident_start(input logic [7:0] c);
        return (c == CH_UNDERSCORE) || is_alpha(c);
    endfunction

    // Single-character tokens; bit 5 flags a hit
    function automatic logic [5:0] punct_kind(input logic [7:0] c);
        logic [5:0] r;
        r = '0;
        unique case (c)
            CH_STAR:   r = {1'b1, KIND_STAR};
            CH_SLASH:  r = {1'b1, KIND_SLASH};
            CH_PLUS:   r = {1'b1, KIND_PLUS};
            CH_MINUS:  r = {1'b1, KIND_MINUS};
            CH_LPAREN: r = {1'b1, KIND_LPAREN};
            CH_RPAREN: r = {1'b1, KIND_RPAREN};
            CH_RBRACE: r = {1'b1, KIND_RBRACE};
            CH_SEMI:   r = {1'b1, KIND_SEMI};
            CH_COMMA:  r = {1'b1, KIND_COMMA};
            CH_DOT:    r = {1'b1, KIND_DOT};
            default:   r = '0;
        endcase
        return r;
    endfunction

    // Keyword idx still matches if byte c sits at position pos
    function automatic logic kw_char_match(input int idx, input logic [7:0] pos,
                                           input logic [7:0] c);
        logic m;
        m = 1'b0;
        for (int p = 0; p < KW_MAX_LEN; p++) begin
            if ((pos == 8'(p)) && (4'(p) < KW_LEN[idx]) && (KW_CHARS[idx][p] == c))
                m = 1'b1;
        end
        return m;
    endfunction

endpackage

@@ sv/pst_lexer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pst_lexer: per-byte lexer state update
// Holds the running token state and turns each accepted byte into zero to
// three result transactions in one pass of combinational logic.
// ----------------------------------------------------------------------------
module pst_lexer #(
    parameter int VALUE_BITS = 32,
    parameter int NAME_BYTES = 8
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           accept,
    input  logic [7:0]     ch,
    input  logic           last_char,
    output pst_pkg::push_t push
);
    import pst_pkg::*;

    localparam int NAME_BITS = 8 * NAME_BYTES;
    localparam int ACC_W     = VALUE_BITS + 4;

    typedef struct packed {
        lex_mode_t              mode;
        logic [VALUE_BITS-1:0]  accum;
        logic                   ovf;
        logic [3:0]             frac;
        logic [NAME_BITS-1:0]   name_buf;
        logic [7:0]             name_cnt;
        logic [KW_COUNT-1:0]    cand;
    } lex_state_t;

    lex_state_t    state_reg;
    lex_state_t    state_next;
    result_t [2:0] res;
    logic [1:0]    n;
    logic          flush_first;
    logic          do_start;
    logic [5:0]    punct;

    function automatic lex_state_t clear_state();
        lex_state_t s;
        s      = '0;
        s.mode = MODE_IDLE;
        s.cand = '1;
        return s;
    endfunction

    // Saturating decimal digit append
    function automatic lex_state_t add_digit(input lex_state_t s, input logic [7:0] c);
        lex_state_t       r;
        logic [ACC_W-1:0] ext;
        logic [ACC_W-1:0] prod;
        logic [7:0]       d;
        r    = s;
        ext  = ACC_W'(s.accum);
        d    = c - CH_ZERO;
        prod = (ext << 3) + (ext << 1) + ACC_W'(d[3:0]);
        if (prod[ACC_W-1:VALUE_BITS] != '0) begin
            r.accum = '1;
            r.ovf   = 1'b1;
        end
        else begin
            r.accum = prod[VALUE_BITS-1:0];
        end
        return r;
    endfunction

    // Identifier byte append with keyword candidate pruning
    function automatic lex_state_t add_name(input lex_state_t s, input logic [7:0] c);
        lex_state_t r;
        r = s;
        for (int j = 0; j < NAME_BYTES; j++) begin
            if (s.name_cnt == 8'(j))
                r.name_buf[8*j +: 8] = c;
        end
        for (int i = 0; i < KW_COUNT; i++) begin
            if (!kw_char_match(i, s.name_cnt, c))
                r.cand[i] = 1'b0;
        end
        if (s.name_cnt != 8'hFF)
            r.name_cnt = s.name_cnt + 8'd1;
        return r;
    endfunction

    function automatic logic has_pending(input lex_state_t s);
        return (s.mode == MODE_IDENT) || (s.mode == MODE_INT) ||
               (s.mode == MODE_FRAC) || (s.mode == MODE_COLON);
    endfunction

    // Token for whatever is pending
    function automatic result_t flush_token(input lex_state_t s);
        result_t     r;
        logic        hit;
        logic [63:0] wide;
        r    = '0;
        hit  = 1'b0;
        wide = 64'(s.accum);
        unique case (s.mode)
            MODE_IDENT: begin
                for (int i = 0; i < KW_COUNT; i++) begin
                    if (!hit && s.cand[i] && (8'(KW_LEN[i]) == s.name_cnt)) begin
                        hit    = 1'b1;
                        r.kind = KIND_FIRST_KW + 5'(i);
                    end
                end
                if (!hit) begin
                    r.kind        = KIND_IDENT;
                    r.name_chars  = 64'(s.name_buf);
                    r.name_length = s.name_cnt;
                end
            end
            MODE_INT: begin
                r.kind       = KIND_INTEGER;
                r.num_value  = wide[31:0];
                r.overflowed = s.ovf;
            end
            MODE_FRAC: begin
                r.kind        = KIND_FLOAT;
                r.num_value   = wide[31:0];
                r.frac_digits = s.frac;
                r.overflowed  = s.ovf;
            end
            default: r.kind = KIND_COLON;
        endcase
        return r;
    endfunction

    // Byte processing
    always_comb
    begin
        state_next  = state_reg;
        res         = '0;
        n           = '0;
        flush_first = 1'b0;
        do_start    = 1'b0;
        punct       = punct_kind(ch);

        unique case (state_reg.mode)
            MODE_ERROR:
            begin
            end
            MODE_COMMENT:
            begin
                if (ch == CH_RBRACE)
                    state_next.mode = MODE_IDLE;
            end
            MODE_IDENT:
            begin
                if (is_ident_start(ch) || is_digit(ch))
                    state_next = add_name(state_next, ch);
                else begin
                    flush_first = 1'b1;
                    do_start    = 1'b1;
                end
            end
            MODE_INT:
            begin
                if (is_digit(ch))
                    state_next = add_digit(state_next, ch);
                else if (ch == CH_DOT)
                    state_next.mode = MODE_FRAC;
                else begin
                    flush_first = 1'b1;
                    do_start    = 1'b1;
                end
            end
            MODE_FRAC:
            begin
                if (is_digit(ch)) begin
                    state_next = add_digit(state_next, ch);
                    if (state_next.frac == 4'hF)
                        state_next.ovf = 1'b1;
                    else
                        state_next.frac = state_next.frac + 4'd1;
                end
                else begin
                    flush_first = 1'b1;
                    do_start    = 1'b1;
                end
            end
            MODE_COLON:
            begin
                if (ch == CH_EQUAL) begin
                    res[n]     = mk_token(KIND_ASSIGN);
                    n          = n + 2'd1;
                    state_next = clear_state();
                end
                else begin
                    flush_first = 1'b1;
                    do_start    = 1'b1;
                end
            end
            default:
            begin
                state_next.mode = MODE_IDLE;
                do_start        = 1'b1;
            end
        endcase

        // End the pending token
        if (flush_first) begin
            if (has_pending(state_next)) begin
                res[n] = flush_token(state_next);
                n      = n + 2'd1;
            end
            state_next = clear_state();
        end

        // Start of a new token
        if (do_start) begin
            priority if (is_space(ch)) begin
            end
            else if (is_digit(ch)) begin
                state_next.mode = MODE_INT;
                state_next      = add_digit(state_next, ch);
            end
            else if (is_ident_start(ch)) begin
                state_next.mode = MODE_IDENT;
                state_next      = add_name(state_next, ch);
            end
            else if (ch == CH_COLON)
                state_next.mode = MODE_COLON;
            else if (ch == CH_LBRACE)
                state_next.mode = MODE_COMMENT;
            else if (punct[5]) begin
                res[n] = mk_token(punct[4:0]);
                n      = n + 2'd1;
            end
            else begin
                res[n]          = mk_token(KIND_ERROR);
                n               = n + 2'd1;
                state_next.mode = MODE_ERROR;
            end
        end

        // Final byte: drain pending token, then end of text
        if (last_char) begin
            if (has_pending(state_next)) begin
                res[n] = flush_token(state_next);
                n      = n + 2'd1;
            end
            res[n]     = mk_token(KIND_END);
            n          = n + 2'd1;
            state_next = clear_state();
        end

        if (n != 2'd0)
            res[n - 2'd1].last_result = 1'b1;
    end

    // Lexer state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= clear_state();
        else if (accept)
            state_reg <= state_next;
    end

    assign push.count = accept ? n : 2'd0;
    assign push.item  = res;

    // Checks
    a_error_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (state_reg.mode == MODE_ERROR) && !last_char) |-> (push.count == 2'd0))
        else $error("lexer produced output while in error mode");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last_char) |->
            ((push.count != 2'd0) && (push.item[push.count - 2'd1].kind == KIND_END)))
        else $error("final byte did not end with an end token");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last_char) |=> (state_reg.mode == MODE_IDLE))
        else $error("lexer state not cleared after final byte");

endmodule

@@ sv/pst_result_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pst_result_queue: result transaction queue
// Small register queue that takes up to three results per cycle from the
// lexer and hands them to the output channel one per cycle unless stalled.
// ----------------------------------------------------------------------------
module pst_result_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  pst_pkg::push_t   push,
    output logic             room,
    output logic             out_valid,
    input  logic             out_stall,
    output pst_pkg::result_t out_item
);
    import pst_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    result_t          entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] head_reg;
    logic [PTR_W-1:0] head_next;
    logic [PTR_W-1:0] tail_reg;
    logic [PTR_W-1:0] tail_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             pop;

    // Pointer and fill arithmetic
    always_comb
    begin
        pop        = out_valid && !out_stall;
        head_next  = head_reg + PTR_W'(pop);
        tail_next  = tail_reg + PTR_W'(push.count);
        count_next = count_reg + CNT_W'(push.count) - CNT_W'(pop);
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < MAX_RESULTS; k++) begin
            if (2'(k) < push.count)
                entry_reg[tail_reg + PTR_W'(k)] <= push.item[k];
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    assign room      = (count_reg <= CNT_W'(QUEUE_DEPTH - MAX_RESULTS));
    assign out_valid = (count_reg != '0);
    assign out_item  = entry_reg[head_reg];

    // Checks
    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("result queue overfilled");

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push.count != 2'd0) |-> room)
        else $error("results pushed without room");

    a_empty_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid && (push.count != 2'd0)) |=> (count_reg == CNT_W'($past(push.count))))
        else $error("queue fill count wrong after push into empty queue");

endmodule

@@ sv/pascal_subset_tokenizer_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pascal_subset_tokenizer_unit: streaming Pascal subset tokenizer
//
// Input channel (in_valid / in_stall): one source byte per transaction, with
// last_char marking the final byte of a source text.
// Output channel (out_valid / out_stall): one token per transaction; each
// input byte yields zero to three tokens, and last_result marks the final
// token caused by that byte.
// Ordering: the tokens of a byte enter the registered result queue and are
// offered behind any older tokens, one per cycle while out_stall is low.
// Throughput: one byte per cycle while bytes yield at most one token each
// and out_stall is low; the output channel carries one token per cycle, and
// the four-entry queue takes a byte only while it can hold three more tokens.
// Reset: lexer state goes idle, keyword candidates all set, queue empties.
// Receiver stall: the head token holds; the queue keeps filling until fewer
// than three entries are free, then in_stall rises.
// ----------------------------------------------------------------------------
module pascal_subset_tokenizer_unit #(
    parameter int VALUE_BITS = 32,
    parameter int NAME_BYTES = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  ch,
    input  logic        last_char,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [4:0]  kind,
    output logic [31:0] num_value,
    output logic [3:0]  frac_digits,
    output logic        overflowed,
    output logic [63:0] name_chars,
    output logic [7:0]  name_length,
    output logic        last_result
);
    import pst_pkg::*;

    logic    accept;
    logic    room;
    push_t   push;
    result_t head_item;

    assign in_stall = !room;
    assign accept   = in_valid && room;

    pst_lexer #(
        .VALUE_BITS (VALUE_BITS),
        .NAME_BYTES (NAME_BYTES)
    ) u_lexer (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .ch        (ch),
        .last_char (last_char),
        .push      (push)
    );

    pst_result_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (head_item)
    );

    // Output payload
    assign kind        = head_item.kind;
    assign num_value   = head_item.num_value;
    assign frac_digits = head_item.frac_digits;
    assign overflowed  = head_item.overflowed;
    assign name_chars  = head_item.name_chars;
    assign name_length = head_item.name_length;
    assign last_result = head_item.last_result;

endmodule

@@ verif/pst_token_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pst_token_checker: token predictor and scoreboard for the tokenizer
// Watches both channels of the tokenizer. Every accepted source byte runs
// through a local copy of the lexer state to produce the tokens it should
// cause; every accepted token is compared field by field with the oldest
// one still waiting. Counts of mismatches, tokens waiting and tokens
// checked go back to the testbench top.
// ----------------------------------------------------------------------------
module pst_token_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  ch,
    input  logic        last_char,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [4:0]  kind,
    input  logic [31:0] num_value,
    input  logic [3:0]  frac_digits,
    input  logic        overflowed,
    input  logic [63:0] name_chars,
    input  logic [7:0]  name_length,
    input  logic        last_result,
    output int          fail_count,
    output int          tokens_pending,
    output int          tokens_checked
);
    import pst_pkg::*;

    // Local lexer state
    lex_mode_t   mode;
    logic [31:0] value_acc;
    logic        value_sat;
    logic [3:0]  frac_count;
    logic [63:0] name_buf;
    logic [7:0]  name_len;
    logic [7:0]  kw_alive;

    result_t     expected_tokens[$];
    result_t     want;
    int          mismatches = 0;
    int          queued     = 0;
    int          matched    = 0;

    assign fail_count     = mismatches;
    assign tokens_pending = queued;
    assign tokens_checked = matched;

    // Keyword spellings, in kind code order
    function automatic string keyword_text(input int idx);
        case (idx)
            0:       return "BEGIN";
            1:       return "END";
            2:       return "PROGRAM";
            3:       return "PROCEDURE";
            4:       return "VAR";
            5:       return "INTEGER";
            6:       return "REAL";
            default: return "DIV";
        endcase
    endfunction

    function automatic bit digit_char(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit letter_char(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic bit blank_char(input logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    task automatic emit_token(input logic [4:0] k, input logic [31:0] v,
                              input logic [3:0] f, input logic sat,
                              input logic [63:0] nm, input logic [7:0] nl);
        result_t r;
        r             = '0;
        r.kind        = k;
        r.num_value   = v;
        r.frac_digits = f;
        r.overflowed  = sat;
        r.name_chars  = nm;
        r.name_length = nl;
        expected_tokens = {expected_tokens, r};
    endtask

    task automatic reset_lexer();
        mode       = MODE_IDLE;
        value_acc  = '0;
        value_sat  = 1'b0;
        frac_count = '0;
        name_buf   = '0;
        name_len   = '0;
        kw_alive   = '1;
    endtask

    // Decimal accumulate, pinned at all ones on overflow
    task automatic accumulate_digit(input logic [7:0] c);
        logic [63:0] d;
        d = 64'(c) - 64'("0");
        if (64'(value_acc) > (64'hFFFF_FFFF - d) / 10) begin
            value_acc = '1;
            value_sat = 1'b1;
        end
        else
            value_acc = 32'(64'(value_acc) * 10 + d);
    endtask

    // Keep the first eight bytes, narrow the keyword candidates
    task automatic append_name_char(input logic [7:0] c);
        string w;
        if (name_len < 8)
            name_buf[8 * name_len +: 8] = c;
        for (int i = 0; i < 8; i++) begin
            w = keyword_text(i);
            if (kw_alive[i] && !(name_len < w.len() && w[name_len] == c))
                kw_alive[i] = 1'b0;
        end
        if (name_len != 8'd255)
            name_len++;
    endtask

    // Emit whatever token is in progress, then go idle
    task automatic close_token();
        string w;
        bit    hit;
        hit = 1'b0;
        case (mode)
            MODE_IDENT: begin
                for (int i = 0; i < 8; i++) begin
                    w = keyword_text(i);
                    if (!hit && kw_alive[i] && w.len() == name_len) begin
                        emit_token(KIND_FIRST_KW + 5'(i), '0, '0, 1'b0, '0, '0);
                        hit = 1'b1;
                    end
                end
                if (!hit)
                    emit_token(KIND_IDENT, '0, '0, 1'b0, name_buf, name_len);
            end
            MODE_INT:   emit_token(KIND_INTEGER, value_acc, '0, value_sat, '0, '0);
            MODE_FRAC:  emit_token(KIND_FLOAT, value_acc, frac_count, value_sat, '0, '0);
            MODE_COLON: emit_token(KIND_COLON, '0, '0, 1'b0, '0, '0);
            default: ;
        endcase
        reset_lexer();
    endtask

    // Byte seen from idle
    task automatic open_token(input logic [7:0] c);
        logic [4:0] sym;
        if (blank_char(c))
            return;
        if (digit_char(c)) begin
            mode = MODE_INT;
            accumulate_digit(c);
            return;
        end
        if (c == CH_UNDERSCORE || letter_char(c)) begin
            mode = MODE_IDENT;
            append_name_char(c);
            return;
        end
        case (c)
            CH_STAR:   sym = KIND_STAR;
            CH_SLASH:  sym = KIND_SLASH;
            CH_PLUS:   sym = KIND_PLUS;
            CH_MINUS:  sym = KIND_MINUS;
            CH_LPAREN: sym = KIND_LPAREN;
            CH_RPAREN: sym = KIND_RPAREN;
            CH_RBRACE: sym = KIND_RBRACE;
            CH_SEMI:   sym = KIND_SEMI;
            CH_COMMA:  sym = KIND_COMMA;
            CH_DOT:    sym = KIND_DOT;
            CH_COLON: begin
                mode = MODE_COLON;
                return;
            end
            CH_LBRACE: begin
                mode = MODE_COMMENT;
                return;
            end
            default: begin
                sym  = KIND_ERROR;
                mode = MODE_ERROR;
            end
        endcase
        emit_token(sym, '0, '0, 1'b0, '0, '0);
    endtask

    // Tokens caused by one source byte
    task automatic predict_byte(input logic [7:0] c, input logic last);
        int      before_cnt;
        result_t tail;
        before_cnt = expected_tokens.size();
        case (mode)
            MODE_ERROR: ;
            MODE_COMMENT: begin
                if (c == CH_RBRACE)
                    mode = MODE_IDLE;
            end
            MODE_IDENT: begin
                if (c == CH_UNDERSCORE || letter_char(c) || digit_char(c))
                    append_name_char(c);
                else begin
                    close_token();
                    open_token(c);
                end
            end
            MODE_INT: begin
                if (digit_char(c))
                    accumulate_digit(c);
                else if (c == CH_DOT)
                    mode = MODE_FRAC;
                else begin
                    close_token();
                    open_token(c);
                end
            end
            MODE_FRAC: begin
                if (digit_char(c)) begin
                    accumulate_digit(c);
                    if (frac_count == 4'd15)
                        value_sat = 1'b1;
                    else
                        frac_count++;
                end
                else begin
                    close_token();
                    open_token(c);
                end
            end
            MODE_COLON: begin
                if (c == CH_EQUAL) begin
                    emit_token(KIND_ASSIGN, '0, '0, 1'b0, '0, '0);
                    reset_lexer();
                end
                else begin
                    close_token();
                    open_token(c);
                end
            end
            default: open_token(c);
        endcase
        // final byte: flush, then the end token
        if (last) begin
            close_token();
            emit_token(KIND_END, '0, '0, 1'b0, '0, '0);
            reset_lexer();
        end
        if (expected_tokens.size() > before_cnt) begin
            tail             = expected_tokens[expected_tokens.size() - 1];
            tail.last_result = 1'b1;
            expected_tokens[expected_tokens.size() - 1] = tail;
        end
    endtask

    task automatic check_field(input string field, input logic [63:0] exp_val,
                               input logic [63:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s: expected 0x%0h, actual 0x%0h", field, exp_val, act_val);
            mismatches++;
        end
    endtask

    // Compare the token leaving this edge, then predict the byte entering
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            reset_lexer();
            expected_tokens.delete();
            queued = 0;
        end
        else begin
            if (out_valid && !out_stall) begin
                if (expected_tokens.size() == 0) begin
                    $error("token with nothing expected: kind %0d", kind);
                    mismatches++;
                end
                else begin
                    want = expected_tokens.pop_front();
                    check_field("kind", 64'(want.kind), 64'(kind));
                    check_field("num_value", 64'(want.num_value), 64'(num_value));
                    check_field("frac_digits", 64'(want.frac_digits), 64'(frac_digits));
                    check_field("overflowed", 64'(want.overflowed), 64'(overflowed));
                    check_field("name_chars", want.name_chars, name_chars);
                    check_field("name_length", 64'(want.name_length), 64'(name_length));
                    check_field("last_result", 64'(want.last_result), 64'(last_result));
                    matched++;
                end
            end
            if (in_valid && !in_stall)
                predict_byte(ch, last_char);
            queued = expected_tokens.size();
        end
    end

endmodule

@@ verif/tb_pascal_subset_tokenizer_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pascal_subset_tokenizer_unit: testbench for the Pascal subset tokenizer
// Feeds short source texts one byte per transaction: a few directed texts
// for the corner cases, one identifier well past the name buffer, then
// random texts built from identifiers, keywords, numbers, symbols, comments
// and stray bytes. The sender runs in bursts, the receiver stalls in
// patterns; the checker module predicts and compares every token.
// ----------------------------------------------------------------------------
module tb_pascal_subset_tokenizer_unit;
    import pst_pkg::*;

    localparam int IDLE_LIMIT  = 2000;
    localparam int ITEM_COUNT  = 260;
    localparam int TAIL_CYCLES = 20;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic [7:0]  ch        = '0;
    logic        last_char = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [4:0]  kind;
    logic [31:0] num_value;
    logic [3:0]  frac_digits;
    logic        overflowed;
    logic [63:0] name_chars;
    logic [7:0]  name_length;
    logic        last_result;

    int          fail_count;
    int          tokens_pending;
    int          tokens_checked;

    logic [7:0]  src[$];
    int          burst_left  = 0;
    bit          gaps_on     = 1'b1;
    int          bytes_sent  = 0;
    int          texts_sent  = 0;
    int          idle_cycles = 0;
    int          stall_style = 0;
    int          stall_left  = 0;

    always #5 clk = ~clk;

    pascal_subset_tokenizer_unit i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .ch          (ch),
        .last_char   (last_char),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .num_value   (num_value),
        .frac_digits (frac_digits),
        .overflowed  (overflowed),
        .name_chars  (name_chars),
        .name_length (name_length),
        .last_result (last_result)
    );

    pst_token_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .ch             (ch),
        .last_char      (last_char),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .kind           (kind),
        .num_value      (num_value),
        .frac_digits    (frac_digits),
        .overflowed     (overflowed),
        .name_chars     (name_chars),
        .name_length    (name_length),
        .last_result    (last_result),
        .fail_count     (fail_count),
        .tokens_pending (tokens_pending),
        .tokens_checked (tokens_checked)
    );

    // Receiver: a random stall style, redrawn each time its countdown runs out
    always @(posedge clk) begin
        if (stall_left == 0) begin
            stall_style <= $urandom_range(0, 3);
            stall_left  <= $urandom_range(20, 120);
        end
        else
            stall_left <= stall_left - 1;
        case (stall_style)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            2:       out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= ((stall_left % 8) < 5);
        endcase
    end

    // Watchdog: too long without any transaction on either channel
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles == IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // One source byte, in bursts with random gaps in between
    task automatic send_byte(input logic [7:0] c, input logic last);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (gaps_on) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
        burst_left--;
        in_valid  <= 1'b1;
        ch        <= c;
        last_char <= last;
        do @(posedge clk); while (in_stall);
        bytes_sent++;
    endtask

    // Whole text, final byte marked
    task automatic send_source();
        for (int i = 0; i < src.size(); i++)
            send_byte(src[i], i == src.size() - 1);
        src.delete();
        texts_sent++;
    endtask

    // Hold off the sender until every predicted token is out
    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(negedge clk); while (tokens_pending != 0);
        @(posedge clk);
    endtask

    // Append one byte to the text being built
    task automatic add_byte(input logic [7:0] b);
        src = {src, b};
    endtask

    task automatic add_str(input string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endtask

    function automatic logic [7:0] pick_digit();
        return CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] pick_name_char(input bit lead);
        int r;
        r = $urandom_range(0, lead ? 52 : 62);
        if (r < 26)
            return CH_LOWER_A + 8'(r);
        else if (r < 52)
            return CH_UPPER_A + 8'(r - 26);
        else if (r == 52)
            return CH_UNDERSCORE;
        else
            return CH_ZERO + 8'(r - 53);
    endfunction

    // Comment body byte: anything but the closing brace
    function automatic logic [7:0] pick_filler();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == CH_RBRACE);
        return b;
    endfunction

    // One token's worth of bytes, occasionally a stray byte
    task automatic add_random_token();
        string sym_chars = "*/+-(),;}.:";
        int    pick;
        int    r;
        int    len;
        int    k;
        pick = $urandom_range(0, 39);
        r    = $urandom_range(0, 8);
        if (pick < 8) begin
            len = $urandom_range(1, 12);
            add_byte(pick_name_char(1'b1));
            repeat (len - 1) add_byte(pick_name_char(1'b0));
        end
        else if (pick < 14) begin
            // keyword: exact, cut short, extended or lowercase
            k   = $urandom_range(0, KW_COUNT - 1);
            len = KW_LEN[k];
            if (r == 6)
                len = len - 1;
            for (int p = 0; p < len; p++)
                add_byte((r == 8) ? (KW_CHARS[k][p] | 8'h20) : KW_CHARS[k][p]);
            if (r == 7)
                add_byte(pick_name_char(1'b0));
        end
        else if (pick < 20) begin
            if (r == 7)
                add_str("4294967295");
            else if (r == 8)
                add_str("4294967296");
            else begin
                len = (r == 6) ? $urandom_range(9, 12) : $urandom_range(1, 4);
                repeat (len) add_byte(pick_digit());
            end
        end
        else if (pick < 25) begin
            repeat ($urandom_range(1, 5)) add_byte(pick_digit());
            add_byte(CH_DOT);
            len = (r == 0) ? $urandom_range(14, 18) : $urandom_range(0, 4);
            repeat (len) add_byte(pick_digit());
        end
        else if (pick < 36) begin
            k = $urandom_range(0, 11);
            if (k == 11)
                add_str(":=");
            else
                add_byte(sym_chars[k]);
        end
        else
            add_byte(8'($urandom_range(0, 255)));
    endtask

    // Between tokens: blanks, a comment, or nothing at all
    task automatic add_spacing();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
            add_byte(CH_SPACE);
        else if (r == 6)
            repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range(9, 13)));
        else if (r == 7) begin
            add_byte(CH_LBRACE);
            repeat ($urandom_range(0, 6)) add_byte(pick_filler());
            add_byte(CH_RBRACE);
        end
        else if (r == 8)
            add_byte(CH_CR);
    endtask

    // Stimulus
    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty comment, colon then letter, identifier flushed at the end
        add_str("{}a:b");
        send_source();
        // float with no fraction, second point, number then letter
        add_str("1..9x");
        send_source();
        // lone equals, NUL and a high byte: error, then silence until the end token
        add_str("=");
        add_byte(8'h00);
        add_byte(8'hFF);
        send_source();
        // comment never closed
        add_str("{c");
        send_source();
        // keyword, colon still pending at the final byte
        add_str("END:");
        send_source();
        add_str("*/+-(),;}:=");
        send_source();
        wait_drained();

        // identifier well past the name buffer
        add_byte(pick_name_char(1'b1));
        repeat (23) add_byte(pick_name_char(1'b0));
        send_source();

        // random texts
        while (bytes_sent < ITEM_COUNT) begin
            gaps_on = ($urandom_range(0, 2) != 0);
            repeat ($urandom_range(1, 12)) begin
                add_random_token();
                add_spacing();
            end
            if ($urandom_range(0, 7) == 0) begin
                add_byte(CH_LBRACE);
                repeat ($urandom_range(0, 4)) add_byte(pick_filler());
            end
            send_source();
            if ($urandom_range(0, 5) == 0)
                wait_drained();
        end

        // drain, then let any stray token show up
        in_valid <= 1'b0;
        do @(negedge clk); while (tokens_pending != 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        @(negedge clk);

        $display("Sent %0d source bytes in %0d texts; %0d tokens compared.",
                 bytes_sent, texts_sent, tokens_checked);
        $display("Covered symbols, keywords, saturating numbers, long names, comments, errors.");
        if (fail_count == 0 && tokens_pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

@@ pascal_subset_tokenizer_unit.f @@
sv/pst_pkg.sv
sv/pst_lexer.sv
sv/pst_result_queue.sv
sv/pascal_subset_tokenizer_unit.sv
verif/pst_token_checker.sv
verif/tb_pascal_subset_tokenizer_unit.sv
